// ===== rtl/ps2_mouse_packet_cursor_tracker_macros.svh =====
// Assertion helpers for the cursor tracker checker.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef PS2_MOUSE_PACKET_CURSOR_TRACKER_MACROS_SVH
`define PS2_MOUSE_PACKET_CURSOR_TRACKER_MACROS_SVH

// Same-cycle implication.
`define PS2MCT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PS2MCT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ps2mct_pkg.sv =====
`timescale 1ns / 1ps
package ps2mct_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CELL_W = 16;
    localparam int unsigned BTN_W  = 3;
    localparam int unsigned AXIS_W = 10;  // signed sum of position and delta

    localparam int unsigned SYNC_POS  = 3;
    localparam int unsigned XSIGN_POS = 4;
    localparam int unsigned YSIGN_POS = 5;

    localparam logic [BYTE_W-1:0] HOME_X     = 8'd40;
    localparam logic [BYTE_W-1:0] HOME_Y     = 8'd12;
    localparam logic [BYTE_W-1:0] COLS_RESET = 8'd80;
    localparam logic [BYTE_W-1:0] ROWS_RESET = 8'd25;

    localparam logic [BYTE_W-1:0] GLYPH_LEFT = 8'h58;
    localparam logic [BYTE_W-1:0] GLYPH_IDLE = 8'h2A;
    localparam logic [BYTE_W-1:0] ATTR_LEFT  = 8'h4F;
    localparam logic [BYTE_W-1:0] ATTR_IDLE  = 8'h1F;

    localparam logic CFG_IDX_COLUMNS = 1'b0;
    localparam logic CFG_IDX_ROWS    = 1'b1;

    typedef enum logic [2:0] {
        PH_FIRST  = 3'b001,
        PH_SECOND = 3'b010,
        PH_THIRD  = 3'b100
    } t_phase;

    // Decoded packet handed from the framer to the cell stage.
    typedef struct packed {
        logic [BYTE_W-1:0] new_x;
        logic [BYTE_W-1:0] new_y;
        logic [BYTE_W-1:0] old_x;
        logic [BYTE_W-1:0] old_y;
        logic [BTN_W-1:0]  buttons;
        logic [BTN_W-1:0]  clicks;
        logic              moved;
    } t_pkt;

    typedef struct packed {
        logic [BYTE_W-1:0] pos_x;
        logic [BYTE_W-1:0] pos_y;
        logic [BTN_W-1:0]  button_bits;
        logic              left_click;
        logic              right_click;
        logic              middle_click;
        logic [CELL_W-1:0] cursor_cell;
        logic [BYTE_W-1:0] cursor_glyph;
        logic [BYTE_W-1:0] cursor_attr;
        logic              erase_valid;
        logic [CELL_W-1:0] erase_cell;
    } t_result;

endpackage

// ===== rtl/ps2mct_byte_if.sv =====
`timescale 1ns / 1ps
interface ps2mct_byte_if import ps2mct_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

// ===== rtl/ps2mct_result_if.sv =====
`timescale 1ns / 1ps
interface ps2mct_result_if import ps2mct_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] pos_x;
    logic [BYTE_W-1:0] pos_y;
    logic [BTN_W-1:0]  button_bits;
    logic              left_click;
    logic              right_click;
    logic              middle_click;
    logic [CELL_W-1:0] cursor_cell;
    logic [BYTE_W-1:0] cursor_glyph;
    logic [BYTE_W-1:0] cursor_attr;
    logic              erase_valid;
    logic [CELL_W-1:0] erase_cell;

    modport source (
        output valid, output pos_x, output pos_y, output button_bits,
        output left_click, output right_click, output middle_click,
        output cursor_cell, output cursor_glyph, output cursor_attr,
        output erase_valid, output erase_cell,
        input ready
    );
    modport sink (
        input valid, input pos_x, input pos_y, input button_bits,
        input left_click, input right_click, input middle_click,
        input cursor_cell, input cursor_glyph, input cursor_attr,
        input erase_valid, input erase_cell,
        output ready
    );
endinterface

// ===== rtl/ps2mct_frame.sv =====
`timescale 1ns / 1ps
module ps2mct_frame import ps2mct_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [BYTE_W-1:0] i_data,
    input  logic [BYTE_W-1:0] i_cols,
    input  logic [BYTE_W-1:0] i_rows,
    output logic              o_done,
    output t_pkt              o_pkt
);

    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_first, n_first;
    logic [BYTE_W-1:0] r_second, n_second;
    logic [BYTE_W-1:0] r_cur_x, n_cur_x;
    logic [BYTE_W-1:0] r_cur_y, n_cur_y;
    logic [BTN_W-1:0]  r_last_btn, n_last_btn;

    logic signed [AXIS_W-1:0] dx, dy, sum_x, sum_y;
    logic [BYTE_W-1:0]        clamp_x, clamp_y;
    logic [BTN_W-1:0]         buttons;

    function automatic logic [BYTE_W-1:0] clamp_axis(
        input logic signed [AXIS_W-1:0] v,
        input logic [BYTE_W-1:0]        size
    );
        logic [BYTE_W-1:0] top;
        top = (size == '0) ? '0 : size - 1'b1;
        if (v < 0) begin
            clamp_axis = '0;
        end else if ($unsigned(v) > {{(AXIS_W-BYTE_W){1'b0}}, top}) begin
            clamp_axis = top;
        end else begin
            clamp_axis = v[BYTE_W-1:0];
        end
    endfunction

    // Nine-bit deltas, sign bits live in the first byte.
    assign dx = {{(AXIS_W-BYTE_W){r_first[XSIGN_POS]}}, r_second};
    assign dy = {{(AXIS_W-BYTE_W){r_first[YSIGN_POS]}}, i_data};

    assign sum_x = $signed({{(AXIS_W-BYTE_W){1'b0}}, r_cur_x}) + dx;
    assign sum_y = $signed({{(AXIS_W-BYTE_W){1'b0}}, r_cur_y}) - dy;

    assign clamp_x = clamp_axis(sum_x, i_cols);
    assign clamp_y = clamp_axis(sum_y, i_rows);
    assign buttons = r_first[BTN_W-1:0];

    always_comb begin
        n_phase    = r_phase;
        n_first    = r_first;
        n_second   = r_second;
        n_cur_x    = r_cur_x;
        n_cur_y    = r_cur_y;
        n_last_btn = r_last_btn;
        o_done     = 1'b0;
        if (i_take) begin
            case (r_phase)
                PH_SECOND: begin
                    n_second = i_data;
                    n_phase  = PH_THIRD;
                end
                PH_THIRD: begin
                    n_phase    = PH_FIRST;
                    n_cur_x    = clamp_x;
                    n_cur_y    = clamp_y;
                    n_last_btn = buttons;
                    o_done     = 1'b1;
                end
                default: begin
                    // drop bytes without the sync bit
                    n_first = i_data;
                    n_phase = i_data[SYNC_POS] ? PH_SECOND : PH_FIRST;
                end
            endcase
        end
    end

    always_comb begin
        o_pkt.new_x   = clamp_x;
        o_pkt.new_y   = clamp_y;
        o_pkt.old_x   = r_cur_x;
        o_pkt.old_y   = r_cur_y;
        o_pkt.buttons = buttons;
        o_pkt.clicks  = buttons & ~r_last_btn;
        o_pkt.moved   = (clamp_x != r_cur_x) || (clamp_y != r_cur_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_FIRST;
            r_first    <= '0;
            r_second   <= '0;
            r_cur_x    <= HOME_X;
            r_cur_y    <= HOME_Y;
            r_last_btn <= '0;
        end else begin
            r_phase    <= n_phase;
            r_first    <= n_first;
            r_second   <= n_second;
            r_cur_x    <= n_cur_x;
            r_cur_y    <= n_cur_y;
            r_last_btn <= n_last_btn;
        end
    end

endmodule

// ===== rtl/ps2_mouse_packet_cursor_tracker.sv =====
`timescale 1ns / 1ps
// PS/2 mouse cursor tracker: takes raw mouse bytes on i_byte, frames them into
// three-byte packets (a packet opens only on a byte with bit 3 set), and for each
// completed packet delivers one word on o_result with the clamped text-grid
// position, buttons, click edges, the cursor cell, glyph and attribute, and the
// cell to erase when the cursor moved. One byte is taken every cycle while the
// packet register is free or can pass on; the word for a packet goes through the
// packet register and the output register behind the cell-index multiply. The grid
// size registers (index 0 columns, index 1 rows) must only be written while no
// packet word is still in flight.
module ps2_mouse_packet_cursor_tracker import ps2mct_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [BYTE_W-1:0] i_cfg_data,
    ps2mct_byte_if.sink       i_byte,
    ps2mct_result_if.source   o_result
);

    logic [BYTE_W-1:0] r_cols, r_rows;
    logic              r_s1_valid;
    t_pkt              r_s1;
    logic              r_out_valid;
    t_result           r_out, n_out;

    logic              in_go, s1_go, frame_done;
    t_pkt              frame_pkt;
    logic [CELL_W-1:0] cur_cell, old_cell;

    assign s1_go           = r_s1_valid && (!r_out_valid || o_result.ready);
    assign i_byte.ready    = !r_s1_valid || s1_go;
    assign in_go           = i_byte.valid && i_byte.ready;

    ps2mct_frame u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (in_go),
        .i_data  (i_byte.data_byte),
        .i_cols  (r_cols),
        .i_rows  (r_rows),
        .o_done  (frame_done),
        .o_pkt   (frame_pkt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= COLS_RESET;
            r_rows <= ROWS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IDX_COLUMNS: r_cols <= i_cfg_data;
                CFG_IDX_ROWS:    r_rows <= i_cfg_data;
                default:         r_rows <= r_rows;
            endcase
        end
    end

    // Cell index: row times columns plus column.
    assign cur_cell = CELL_W'(r_s1.new_y) * CELL_W'(r_cols) + CELL_W'(r_s1.new_x);
    assign old_cell = CELL_W'(r_s1.old_y) * CELL_W'(r_cols) + CELL_W'(r_s1.old_x);

    always_comb begin
        n_out.pos_x        = r_s1.new_x;
        n_out.pos_y        = r_s1.new_y;
        n_out.button_bits  = r_s1.buttons;
        n_out.left_click   = r_s1.clicks[0];
        n_out.right_click  = r_s1.clicks[1];
        n_out.middle_click = r_s1.clicks[2];
        n_out.cursor_cell  = cur_cell;
        n_out.cursor_glyph = r_s1.buttons[0] ? GLYPH_LEFT : GLYPH_IDLE;
        n_out.cursor_attr  = r_s1.buttons[0] ? ATTR_LEFT : ATTR_IDLE;
        n_out.erase_valid  = r_s1.moved;
        n_out.erase_cell   = r_s1.moved ? old_cell : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_go && frame_done) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_go) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_go && frame_done) begin
            r_s1 <= frame_pkt;
        end
        if (s1_go) begin
            r_out <= n_out;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.pos_x        = r_out.pos_x;
    assign o_result.pos_y        = r_out.pos_y;
    assign o_result.button_bits  = r_out.button_bits;
    assign o_result.left_click   = r_out.left_click;
    assign o_result.right_click  = r_out.right_click;
    assign o_result.middle_click = r_out.middle_click;
    assign o_result.cursor_cell  = r_out.cursor_cell;
    assign o_result.cursor_glyph = r_out.cursor_glyph;
    assign o_result.cursor_attr  = r_out.cursor_attr;
    assign o_result.erase_valid  = r_out.erase_valid;
    assign o_result.erase_cell   = r_out.erase_cell;

endmodule

// ===== rtl/ps2mct_checker.sv =====
`timescale 1ns / 1ps
`include "ps2_mouse_packet_cursor_tracker_macros.svh"
module ps2mct_checker import ps2mct_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              i_ready,
    input logic [BYTE_W-1:0] i_pos_x,
    input logic [BTN_W-1:0]  i_buttons,
    input logic              i_left_click,
    input logic              i_right_click,
    input logic              i_middle_click,
    input logic [BYTE_W-1:0] i_glyph,
    input logic [BYTE_W-1:0] i_attr,
    input logic              i_erase_valid,
    input logic [CELL_W-1:0] i_erase_cell
);

    `PS2MCT_ASSERT_NEXT(a_hold_valid, i_valid && !i_ready, i_valid, "word dropped while stalled")
    `PS2MCT_ASSERT_NEXT(a_hold_data, i_valid && !i_ready, $stable(i_pos_x) && $stable(i_buttons), "word changed while stalled")
    `PS2MCT_ASSERT_NOW(a_click_pressed, i_valid, ((i_left_click && !i_buttons[0]) || (i_right_click && !i_buttons[1]) || (i_middle_click && !i_buttons[2])) == 1'b0, "click without button pressed")
    `PS2MCT_ASSERT_NOW(a_look, i_valid, i_buttons[0] ? (i_glyph == GLYPH_LEFT && i_attr == ATTR_LEFT) : (i_glyph == GLYPH_IDLE && i_attr == ATTR_IDLE), "cursor look mismatch")
    `PS2MCT_ASSERT_NOW(a_erase_zero, i_valid && !i_erase_valid, i_erase_cell == '0, "erase cell set without move")

endmodule

bind ps2_mouse_packet_cursor_tracker ps2mct_checker u_ps2mct_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_result.valid),
    .i_ready        (o_result.ready),
    .i_pos_x        (o_result.pos_x),
    .i_buttons      (o_result.button_bits),
    .i_left_click   (o_result.left_click),
    .i_right_click  (o_result.right_click),
    .i_middle_click (o_result.middle_click),
    .i_glyph        (o_result.cursor_glyph),
    .i_attr         (o_result.cursor_attr),
    .i_erase_valid  (o_result.erase_valid),
    .i_erase_cell   (o_result.erase_cell)
);
